/* hdl/tps_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tps_pkg: shared types and constants of the triangle plane slicer
// Widths of the fixed-point datapath, register map and queue item layout.
// ----------------------------------------------------------------------------
package tps_pkg;

    localparam int XW    = 32;          // Q16.16 coordinate
    localparam int MW    = XW + 1;      // coordinate difference
    localparam int PW    = MW + XW;     // difference times normal
    localparam int DW    = 67;          // signed distance, Q.32
    localparam int MAW   = 66;          // distance magnitude
    localparam int HALF  = MAW / 2;     // partial product split
    localparam int NUMW  = 98;          // crossing numerator
    localparam int DENW  = 67;          // crossing denominator
    localparam int QW    = 33;          // crossing quotient bits
    localparam int REMW  = DENW;        // divider remainder
    localparam int DIV_LAT = QW + 2;    // load, quotient steps, result
    localparam int FRONT_LAT = 7;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;
    localparam int QDEPTH = 4;

    localparam logic [XW-1:0] NORMAL_Z_RST = 32'd65536;
    localparam logic [XW-1:0] TOL_RST      = 32'd43;

    typedef enum logic [2:0] {
        REG_NORMAL_X = 3'd0,
        REG_NORMAL_Y = 3'd1,
        REG_NORMAL_Z = 3'd2,
        REG_ORIGIN_X = 3'd3,
        REG_ORIGIN_Y = 3'd4,
        REG_ORIGIN_Z = 3'd5,
        REG_TOL      = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic [2:0][XW-1:0] normal;     // x, y, z
        logic [2:0][XW-1:0] origin;
        logic [XW-1:0]      tol;
    } cfg_t;

    // one endpoint coordinate is base +/- round(num / den)
    typedef struct packed {
        logic                         found;
        logic [1:0][2:0][XW-1:0]      base;
        logic [1:0][2:0]              neg;
        logic [1:0][2:0][NUMW-1:0]    num;
        logic [1:0][DENW-1:0]         den;
    } xing_t;

endpackage
`default_nettype wire

/* hdl/tps_cfg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tps_cfg: plane configuration registers
// APB register file holding the plane normal, origin and on-plane tolerance.
// ----------------------------------------------------------------------------
module tps_cfg (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire  [tps_pkg::ADDR_W-1:0]   paddr,
    input  wire  [tps_pkg::DATA_W-1:0]   pwdata,
    output logic [tps_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    output tps_pkg::cfg_t                cfg
);
    import tps_pkg::*;

    cfg_t     cfg_reg;
    logic     wr;
    reg_idx_t idx;

    assign pready = 1'b1;
    assign wr     = psel & penable & pwrite;
    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.normal <= {NORMAL_Z_RST, {XW{1'b0}}, {XW{1'b0}}};
            cfg_reg.origin <= '0;
            cfg_reg.tol    <= TOL_RST;
        end else if (wr) begin
            case (idx)
                REG_NORMAL_X: cfg_reg.normal[0] <= pwdata;
                REG_NORMAL_Y: cfg_reg.normal[1] <= pwdata;
                REG_NORMAL_Z: cfg_reg.normal[2] <= pwdata;
                REG_ORIGIN_X: cfg_reg.origin[0] <= pwdata;
                REG_ORIGIN_Y: cfg_reg.origin[1] <= pwdata;
                REG_ORIGIN_Z: cfg_reg.origin[2] <= pwdata;
                REG_TOL:      cfg_reg.tol       <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_NORMAL_X: prdata = cfg_reg.normal[0];
            REG_NORMAL_Y: prdata = cfg_reg.normal[1];
            REG_NORMAL_Z: prdata = cfg_reg.normal[2];
            REG_ORIGIN_X: prdata = cfg_reg.origin[0];
            REG_ORIGIN_Y: prdata = cfg_reg.origin[1];
            REG_ORIGIN_Z: prdata = cfg_reg.origin[2];
            REG_TOL:      prdata = cfg_reg.tol;
            default:      prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

/* hdl/tps_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tps_front: distance, classification and crossing set-up
// Seven-stage pipeline: vertex distances, case selection, numerators and
// denominators of up to two crossings; stalls only when the queue is full.
// ----------------------------------------------------------------------------
module tps_front (
    input  wire                                      aclk,
    input  wire                                      aresetn,
    input  tps_pkg::cfg_t                            cfg,
    input  wire                                      in_valid,
    output logic                                     in_ready,
    input  wire  [2:0][2:0][tps_pkg::XW-1:0]         in_data,
    input  wire                                      q_full,
    output logic                                     push,
    output tps_pkg::xing_t                           push_data
);
    import tps_pkg::*;

    logic                         en;
    logic [FRONT_LAT-1:0]         vld_reg;

    logic [2:0][2:0][XW-1:0]      v1_reg, v2_reg, v3_reg;
    logic [2:0][2:0][MW-1:0]      df1_reg;
    logic [2:0][2:0][PW-1:0]      pr2_reg;
    logic [2:0][DW-1:0]           d3_reg;

    // selection result
    logic                         f4_found_next, f4_found_reg;
    logic [1:0]                   f4_dir_next, f4_dir_reg;
    logic [1:0][2:0][XW-1:0]      f4_a_next, f4_a_reg, f4_b_next, f4_b_reg;
    logic [1:0][DW-1:0]           f4_da_next, f4_da_reg, f4_db_next, f4_db_reg;

    logic                         f5_found_reg;
    logic [1:0][2:0][XW-1:0]      f5_a_reg;
    logic [1:0][2:0]              f5_neg_reg;
    logic [1:0][2:0][MW-1:0]      f5_m_reg;
    logic [1:0][MAW-1:0]          f5_ma_reg;
    logic [1:0][DENW-1:0]         f5_den_reg;

    logic                         f6_found_reg;
    logic [1:0][2:0][XW-1:0]      f6_a_reg;
    logic [1:0][2:0]              f6_neg_reg;
    logic [1:0][2:0][2*MW-1:0]    f6_plo_reg, f6_phi_reg;
    logic [1:0][DENW-1:0]         f6_den_reg;

    xing_t                        f7_reg;

    function automatic logic [DW-1:0] mag_of(input logic [DW-1:0] d);
        mag_of = d[DW-1] ? (~d + 1'b1) : d;
    endfunction

    assign en       = !q_full;
    assign in_ready = en;
    assign push     = en && vld_reg[FRONT_LAT-1];
    assign push_data = f7_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[FRONT_LAT-2:0], in_valid};
        end
    end

    // distances
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                for (int k = 0; k < 3; k++) begin
                    df1_reg[i][k] <= MW'($signed(in_data[i][k]))
                                   - MW'($signed(cfg.origin[k]));
                    pr2_reg[i][k] <= PW'($signed(df1_reg[i][k]) * $signed(cfg.normal[k]));
                end
                d3_reg[i] <= DW'($signed(pr2_reg[i][0])) + DW'($signed(pr2_reg[i][1]))
                           + DW'($signed(pr2_reg[i][2]));
            end
            v1_reg <= in_data;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // classify vertices and pick the edges to cross
    always_comb begin
        logic [DW-1:0] mag;
        logic [2:0]    pos, ngt, zer;
        logic [1:0]    npos, nneg, nzero;
        logic [1:0]    lone, j1, j2, on, ia, ib, z0, z1;
        logic          want_pos, seen_a, seen_z;

        for (int i = 0; i < 3; i++) begin
            mag    = mag_of(d3_reg[i]);
            zer[i] = mag <= DW'(cfg.tol);
            pos[i] = !zer[i] && !d3_reg[i][DW-1];
            ngt[i] = !zer[i] && d3_reg[i][DW-1];
        end
        npos  = {1'b0, pos[0]} + {1'b0, pos[1]} + {1'b0, pos[2]};
        nneg  = {1'b0, ngt[0]} + {1'b0, ngt[1]} + {1'b0, ngt[2]};
        nzero = {1'b0, zer[0]} + {1'b0, zer[1]} + {1'b0, zer[2]};

        want_pos = npos == 2'd1;
        lone = 2'd0; on = 2'd0; ia = 2'd0; ib = 2'd0; z0 = 2'd0; z1 = 2'd0;
        seen_a = 1'b0; seen_z = 1'b0;
        for (int i = 0; i < 3; i++) begin
            if (want_pos ? pos[i] : ngt[i]) lone = 2'(i);
            if (zer[i]) begin
                on = 2'(i);
                if (!seen_z) begin
                    z0 = 2'(i);
                    seen_z = 1'b1;
                end else begin
                    z1 = 2'(i);
                end
            end else if (!seen_a) begin
                ia = 2'(i);
                seen_a = 1'b1;
            end else begin
                ib = 2'(i);
            end
        end
        j1 = (lone == 2'd2) ? 2'd0 : lone + 2'd1;
        j2 = (lone == 2'd0) ? 2'd2 : lone - 2'd1;

        // no segment: both endpoints held at zero
        f4_found_next = 1'b0;
        f4_dir_next   = 2'b11;
        f4_a_next     = '0;
        f4_b_next     = '0;
        f4_da_next    = '0;
        f4_db_next    = '0;

        if (nzero == 2'd0 && npos != 2'd0 && nneg != 2'd0) begin
            f4_found_next = 1'b1;
            f4_dir_next   = 2'b00;
            f4_a_next[0]  = v3_reg[lone];
            f4_b_next[0]  = v3_reg[j1];
            f4_da_next[0] = d3_reg[lone];
            f4_db_next[0] = d3_reg[j1];
            f4_a_next[1]  = v3_reg[lone];
            f4_b_next[1]  = v3_reg[j2];
            f4_da_next[1] = d3_reg[lone];
            f4_db_next[1] = d3_reg[j2];
        end else if (nzero == 2'd1 && npos == 2'd1) begin
            f4_found_next = 1'b1;
            f4_dir_next   = 2'b01;
            f4_a_next[0]  = v3_reg[on];
            f4_b_next[0]  = v3_reg[on];
            f4_a_next[1]  = v3_reg[ia];
            f4_b_next[1]  = v3_reg[ib];
            f4_da_next[1] = d3_reg[ia];
            f4_db_next[1] = d3_reg[ib];
        end else if (nzero == 2'd2 && npos == 2'd1) begin
            f4_found_next = 1'b1;
            f4_a_next[0]  = v3_reg[z0];
            f4_b_next[0]  = v3_reg[z0];
            f4_a_next[1]  = v3_reg[z1];
            f4_b_next[1]  = v3_reg[z1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f4_found_reg <= f4_found_next;
            f4_dir_reg   <= f4_dir_next;
            f4_a_reg     <= f4_a_next;
            f4_b_reg     <= f4_b_next;
            f4_da_reg    <= f4_da_next;
            f4_db_reg    <= f4_db_next;
        end
    end

    // edge spans, distance magnitudes, denominators
    always_ff @(posedge aclk) begin
        if (en) begin
            f5_found_reg <= f4_found_reg;
            f5_a_reg     <= f4_a_reg;
            for (int l = 0; l < 2; l++) begin
                logic [MW-1:0] dd;
                logic [DW-1:0] ma, mb;
                ma = mag_of(f4_da_reg[l]);
                mb = mag_of(f4_db_reg[l]);
                f5_ma_reg[l]  <= ma[MAW-1:0];
                // an endpoint taken straight from a vertex divides by one
                f5_den_reg[l] <= f4_dir_reg[l] ? DENW'(1) : DENW'(ma + mb);
                for (int k = 0; k < 3; k++) begin
                    dd = MW'($signed(f4_b_reg[l][k])) - MW'($signed(f4_a_reg[l][k]));
                    f5_neg_reg[l][k] <= dd[MW-1];
                    f5_m_reg[l][k]   <= dd[MW-1] ? (~dd + 1'b1) : dd;
                end
            end
        end
    end

    // numerator partial products
    always_ff @(posedge aclk) begin
        if (en) begin
            f6_found_reg <= f5_found_reg;
            f6_a_reg     <= f5_a_reg;
            f6_neg_reg   <= f5_neg_reg;
            f6_den_reg   <= f5_den_reg;
            for (int l = 0; l < 2; l++) begin
                for (int k = 0; k < 3; k++) begin
                    f6_plo_reg[l][k] <= f5_ma_reg[l][HALF-1:0] * f5_m_reg[l][k];
                    f6_phi_reg[l][k] <= f5_ma_reg[l][MAW-1:HALF] * f5_m_reg[l][k];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f7_reg.found <= f6_found_reg;
            f7_reg.base  <= f6_a_reg;
            f7_reg.neg   <= f6_neg_reg;
            f7_reg.den   <= f6_den_reg;
            for (int l = 0; l < 2; l++) begin
                for (int k = 0; k < 3; k++) begin
                    f7_reg.num[l][k] <= NUMW'(f6_plo_reg[l][k])
                                      + NUMW'({f6_phi_reg[l][k], {HALF{1'b0}}});
                end
            end
        end
    end

endmodule
`default_nettype wire

/* hdl/tps_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tps_queue: crossing job queue
// Short FIFO between the set-up front and the divider back.
// ----------------------------------------------------------------------------
module tps_queue #(
    parameter int DEPTH = tps_pkg::QDEPTH
) (
    input  wire             aclk,
    input  wire             aresetn,
    input  wire             push,
    input  tps_pkg::xing_t  push_data,
    input  wire             pop,
    output tps_pkg::xing_t  pop_data,
    output logic            full,
    output logic            empty
);
    import tps_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    xing_t          mem [DEPTH];
    logic [AW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]  count_reg;

    assign full     = count_reg == CW'(DEPTH);
    assign empty    = count_reg == '0;
    assign pop_data = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

/* hdl/tps_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tps_div: pipelined crossing divider
// Restoring division, one quotient bit per stage, rounded half away from
// zero and applied to the edge start coordinate.
// ----------------------------------------------------------------------------
module tps_div (
    input  wire                          aclk,
    input  wire                          en,
    input  wire  [tps_pkg::NUMW-1:0]     num,
    input  wire  [tps_pkg::DENW-1:0]     den,
    input  wire  [tps_pkg::XW-1:0]       base,
    input  wire                          neg,
    output logic [tps_pkg::XW-1:0]       result
);
    import tps_pkg::*;

    logic [REMW-1:0]  rem_reg  [QW+1];
    logic [QW-1:0]    low_reg  [QW+1];
    logic [QW-1:0]    quo_reg  [QW+1];
    logic [DENW-1:0]  den_reg  [QW+1];
    logic [XW-1:0]    base_reg [QW+1];
    logic             neg_reg  [QW+1];
    logic [XW-1:0]    result_reg;

    assign result = result_reg;

    // the quotient stays below 2^QW, so the top bits are already under den
    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]  <= REMW'(num[NUMW-1:QW]);
            low_reg[0]  <= num[QW-1:0];
            quo_reg[0]  <= '0;
            den_reg[0]  <= den;
            base_reg[0] <= base;
            neg_reg[0]  <= neg;
        end
    end

    for (genvar s = 0; s < QW; s++) begin : g_step
        logic [REMW:0] trial;
        logic          ge;
        logic [REMW:0] diff;

        assign trial = {rem_reg[s], low_reg[s][QW-1]};
        assign ge    = trial >= {1'b0, den_reg[s]};
        assign diff  = trial - {1'b0, den_reg[s]};

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[s+1]  <= ge ? diff[REMW-1:0] : trial[REMW-1:0];
                low_reg[s+1]  <= {low_reg[s][QW-2:0], 1'b0};
                quo_reg[s+1]  <= {quo_reg[s][QW-2:0], ge};
                den_reg[s+1]  <= den_reg[s];
                base_reg[s+1] <= base_reg[s];
                neg_reg[s+1]  <= neg_reg[s];
            end
        end
    end

    // round half away from zero, then step from the edge start
    always_ff @(posedge aclk) begin
        logic          up;
        logic [QW:0]   qr;
        if (en) begin
            up = {rem_reg[QW], 1'b0} >= {1'b0, den_reg[QW]};
            qr = {1'b0, quo_reg[QW]} + (QW+1)'(up);
            result_reg <= neg_reg[QW] ? base_reg[QW] - qr[XW-1:0]
                                      : base_reg[QW] + qr[XW-1:0];
        end
    end

endmodule
`default_nettype wire

/* hdl/tps_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tps_back: crossing evaluation and result register
// Six divider lanes (two endpoints, three axes) feeding the output register.
// ----------------------------------------------------------------------------
module tps_back (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    input  wire                                  q_empty,
    input  tps_pkg::xing_t                       q_data,
    output logic                                 pop,
    output logic                                 out_valid,
    input  wire                                  out_ready,
    output logic                                 out_found,
    output logic [1:0][2:0][tps_pkg::XW-1:0]     out_point
);
    import tps_pkg::*;

    logic                     en;
    logic [DIV_LAT-1:0]       vld_reg;
    logic [DIV_LAT-1:0]       found_reg;
    logic [1:0][2:0][XW-1:0]  lane_res;
    logic                     out_vld_reg;
    logic                     out_found_reg;
    logic [1:0][2:0][XW-1:0]  out_point_reg;

    // advance whenever the result register is free or being emptied
    assign en        = !out_vld_reg || out_ready;
    assign pop       = en && !q_empty;
    assign out_valid = out_vld_reg;
    assign out_found = out_found_reg;
    assign out_point = out_point_reg;

    for (genvar l = 0; l < 2; l++) begin : g_end
        for (genvar k = 0; k < 3; k++) begin : g_axis
            tps_div u_div (
                .aclk   (aclk),
                .en     (en),
                .num    (q_data.num[l][k]),
                .den    (q_data.den[l]),
                .base   (q_data.base[l][k]),
                .neg    (q_data.neg[l][k]),
                .result (lane_res[l][k])
            );
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg     <= {vld_reg[DIV_LAT-2:0], pop};
            out_vld_reg <= vld_reg[DIV_LAT-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            found_reg     <= {found_reg[DIV_LAT-2:0], q_data.found};
            out_found_reg <= found_reg[DIV_LAT-1];
            out_point_reg <= lane_res;
        end
    end

endmodule
`default_nettype wire

/* hdl/triangle_plane_slice.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// triangle_plane_slice: slice one triangle by a configured plane
// Classifies the three vertices against the plane and gives the segment
// where the triangle crosses it, one result per triangle.
// ----------------------------------------------------------------------------
// Takes one triangle per clock unless the queue is full, and returns one result
// per triangle, in order. A triangle passes the set-up front (distances,
// classification, numerator products), a 4-entry queue, the divider lanes
// and the output register. The rate is set by the six crossing dividers,
// each a pipeline of 33 restoring stages that takes a new job every cycle
// while the output register is free or being emptied. When no segment
// exists m_tuser is 0 and all endpoints read 0. Write the plane registers
// only while no triangle is in flight.
// ----------------------------------------------------------------------------
module triangle_plane_slice #(
    parameter int QUEUE_DEPTH = tps_pkg::QDEPTH
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire  [tps_pkg::ADDR_W-1:0]   paddr,
    input  wire  [tps_pkg::DATA_W-1:0]   pwdata,
    output logic [tps_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    input  wire                          s_tvalid,
    output logic                         s_tready,
    // vertex0_x, vertex0_y, vertex0_z, vertex1_x .. vertex2_z
    input  wire  [287:0]                 s_tdata,
    output logic                         m_tvalid,
    input  wire                          m_tready,
    // start_x, start_y, start_z, end_x, end_y, end_z
    output logic [191:0]                 m_tdata,
    // segment_found
    output logic [0:0]                   m_tuser
);
    import tps_pkg::*;

    cfg_t                     cfg;
    xing_t                    push_data, pop_data;
    logic                     push, pop, q_full, q_empty;
    logic                     out_found;
    logic [1:0][2:0][XW-1:0]  out_point;

    tps_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tps_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (s_tdata),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data)
    );

    tps_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    tps_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_empty   (q_empty),
        .q_data    (pop_data),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_found (out_found),
        .out_point (out_point)
    );

    assign m_tdata = out_point;
    assign m_tuser = out_found;

`ifndef ASSERT_OFF
    a_empty_segment: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0)
        else $error("missing segment with nonzero endpoints");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("block not idle after reset");

    a_tol_write: assert property (@(posedge aclk) disable iff (!aresetn)
        psel && penable && pwrite && paddr[ADDR_W-1:2] == REG_TOL |=>
        cfg.tol == $past(pwdata))
        else $error("tolerance register write lost");
`endif

endmodule
`default_nettype wire
